// ===== hw/rtl/rc4_drop_stream_decrypt_defines.svh =====
`ifndef RC4_DROP_STREAM_DECRYPT_DEFINES_SVH
`define RC4_DROP_STREAM_DECRYPT_DEFINES_SVH

// Checks that hold in the same cycle. The enclosing module has aclk and aresetn.
`define RC4D_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rc4d: same-cycle check failed");

// Checks that hold in the cycle after the antecedent.
`define RC4D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rc4d: next-cycle check failed");

`endif

// ===== hw/rtl/rc4d_pkg.sv =====
`timescale 1ns / 1ps

package rc4d_pkg;

    localparam int DROP_COUNT    = 3072;
    localparam int MAX_KEY_BYTES = 32;
    localparam int SBOX_DEPTH    = 256;

    localparam int KLEN_W = 6;
    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int DROP_W = $clog2(DROP_COUNT + 2);
    localparam int CFG_W  = 64;
    localparam int CIDX_W = 3;
    localparam int STEP_W = 5;

    // Input item kinds.
    localparam logic FUNC_REKEY   = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_KEY_LENGTH = 3'd0;
    localparam logic [CIDX_W-1:0] REG_KEY_LOW    = 3'd1;
    localparam logic [CIDX_W-1:0] REG_KEY_SECOND = 3'd2;
    localparam logic [CIDX_W-1:0] REG_KEY_THIRD  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_KEY_HIGH   = 3'd4;

    typedef logic [STEP_W-1:0] step_t;

    // Microprogram addresses.
    localparam step_t S_INIT  = 5'd0;
    localparam step_t S_K0    = 5'd1;
    localparam step_t S_K1    = 5'd2;
    localparam step_t S_K2    = 5'd3;
    localparam step_t S_K3    = 5'd4;
    localparam step_t S_DSET  = 5'd5;
    localparam step_t S_DG0   = 5'd6;
    localparam step_t S_DG1   = 5'd7;
    localparam step_t S_DG2   = 5'd8;
    localparam step_t S_DG3   = 5'd9;
    localparam step_t S_DG4   = 5'd10;
    localparam step_t S_KEYED = 5'd11;
    localparam step_t S_G0    = 5'd12;
    localparam step_t S_G1    = 5'd13;
    localparam step_t S_G2    = 5'd14;
    localparam step_t S_G3    = 5'd15;
    localparam step_t S_G4    = 5'd16;
    localparam step_t S_ERR   = 5'd17;
    localparam step_t S_LAST  = S_ERR;

    typedef enum logic [1:0] {RD_N, RD_J_NEXT, RD_I_NEXT, RD_SUM} rd_sel_t;
    typedef enum logic [1:0] {WA_N, WA_J, WA_I} wa_sel_t;
    typedef enum logic [1:0] {WD_N, WD_A, WD_B} wd_sel_t;
    typedef enum logic [1:0] {J_HOLD, J_CLR, J_KSA, J_GEN} j_op_t;
    typedef enum logic [1:0] {I_HOLD, I_CLR, I_INC} i_op_t;
    typedef enum logic [1:0] {K_HOLD, K_CLR, K_STEP} k_op_t;
    typedef enum logic [1:0] {D_HOLD, D_LOAD, D_DEC} drop_op_t;
    typedef enum logic [1:0] {E_NONE, E_PLAIN, E_ERR} emit_t;
    typedef enum logic [1:0] {C_NEVER, C_N_MORE, C_DROP_MORE, C_DROP_NONE} cond_t;

    typedef struct packed {
        logic     re;
        rd_sel_t  rd_sel;
        logic     we;
        wa_sel_t  wa_sel;
        wd_sel_t  wd_sel;
        logic     n_inc;
        j_op_t    j_op;
        i_op_t    i_op;
        k_op_t    k_op;
        logic     a_ld;
        logic     b_ld;
        drop_op_t drop_op;
        logic     set_keyed;
        emit_t    emit;
        cond_t    cond;
        step_t    target;
        logic     last;
    } ctrl_t;

    typedef struct packed {
        logic n_more;
        logic drop_more;
        logic keyed;
    } stat_t;

    localparam ctrl_t CW_NOP = ctrl_t'('0);

    // Control store. The generation step appears twice: once for the drop loop
    // and once for a decrypt word.
    function automatic ctrl_t ucode_rom(input step_t step);
        ctrl_t cw;
        cw = CW_NOP;
        case (step)
            S_INIT: begin
                cw.we     = 1'b1;
                cw.wa_sel = WA_N;
                cw.wd_sel = WD_N;
                cw.n_inc  = 1'b1;
                cw.j_op   = J_CLR;
                cw.k_op   = K_CLR;
                cw.cond   = C_N_MORE;
                cw.target = S_INIT;
            end
            S_K0: begin
                cw.re     = 1'b1;
                cw.rd_sel = RD_N;
            end
            S_K1: begin
                cw.re     = 1'b1;
                cw.rd_sel = RD_J_NEXT;
                cw.j_op   = J_KSA;
                cw.a_ld   = 1'b1;
            end
            S_K2: begin
                cw.b_ld   = 1'b1;
                cw.we     = 1'b1;
                cw.wa_sel = WA_J;
                cw.wd_sel = WD_A;
            end
            S_K3: begin
                cw.we     = 1'b1;
                cw.wa_sel = WA_N;
                cw.wd_sel = WD_B;
                cw.n_inc  = 1'b1;
                cw.k_op   = K_STEP;
                cw.cond   = C_N_MORE;
                cw.target = S_K0;
            end
            S_DSET: begin
                cw.i_op    = I_CLR;
                cw.j_op    = J_CLR;
                cw.drop_op = D_LOAD;
                cw.cond    = C_DROP_NONE;
                cw.target  = S_KEYED;
            end
            S_DG0, S_G0: begin
                cw.re     = 1'b1;
                cw.rd_sel = RD_I_NEXT;
                cw.i_op   = I_INC;
            end
            S_DG1, S_G1: begin
                cw.re     = 1'b1;
                cw.rd_sel = RD_J_NEXT;
                cw.j_op   = J_GEN;
                cw.a_ld   = 1'b1;
            end
            S_DG2, S_G2: begin
                cw.b_ld   = 1'b1;
                cw.we     = 1'b1;
                cw.wa_sel = WA_J;
                cw.wd_sel = WD_A;
            end
            S_DG3, S_G3: begin
                cw.we     = 1'b1;
                cw.wa_sel = WA_I;
                cw.wd_sel = WD_B;
                cw.re     = 1'b1;
                cw.rd_sel = RD_SUM;
            end
            S_DG4: begin
                cw.drop_op = D_DEC;
                cw.cond    = C_DROP_MORE;
                cw.target  = S_DG0;
            end
            S_KEYED: begin
                cw.set_keyed = 1'b1;
                cw.last      = 1'b1;
            end
            S_G4: begin
                cw.emit = E_PLAIN;
                cw.last = 1'b1;
            end
            S_ERR: begin
                cw.emit = E_ERR;
                cw.last = 1'b1;
            end
            default: begin
                cw = CW_NOP;
            end
        endcase
        return cw;
    endfunction

endpackage

// ===== hw/rtl/rc4d_seq.sv =====
`timescale 1ns / 1ps
`include "rc4_drop_stream_decrypt_defines.svh"

module rc4d_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic                  func,
    input  rc4d_pkg::stat_t       stat,
    input  logic                  out_full,
    output logic                  busy,
    output rc4d_pkg::ctrl_t       cw
);

    logic                busy_reg, busy_next;
    rc4d_pkg::step_t     pc_reg, pc_next;
    rc4d_pkg::ctrl_t     rom_cw;
    logic                stall;
    logic                take_jump;

    assign rom_cw = rc4d_pkg::ucode_rom(pc_reg);

    // A result step waits while the output register still holds an untaken word.
    assign stall = busy_reg && (rom_cw.emit != rc4d_pkg::E_NONE) && out_full;
    assign cw    = (busy_reg && !stall) ? rom_cw : rc4d_pkg::CW_NOP;
    assign busy  = busy_reg;

    always_comb begin
        case (rom_cw.cond)
            rc4d_pkg::C_NEVER:     take_jump = 1'b0;
            rc4d_pkg::C_N_MORE:    take_jump = stat.n_more;
            rc4d_pkg::C_DROP_MORE: take_jump = stat.drop_more;
            rc4d_pkg::C_DROP_NONE: take_jump = (rc4d_pkg::DROP_COUNT == 0);
            default:               take_jump = 1'b0;
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (!busy_reg) begin
            if (start) begin
                busy_next = 1'b1;
                if (func == rc4d_pkg::FUNC_REKEY) begin
                    pc_next = rc4d_pkg::S_INIT;
                end else if (stat.keyed) begin
                    pc_next = rc4d_pkg::S_G0;
                end else begin
                    pc_next = rc4d_pkg::S_ERR;
                end
            end
        end else if (!stall) begin
            if (rom_cw.last) begin
                busy_next = 1'b0;
            end else if (take_jump) begin
                pc_next = rom_cw.target;
            end else begin
                pc_next = pc_reg + rc4d_pkg::step_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg   <= rc4d_pkg::S_INIT;
        end else begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    `RC4D_ASSERT_SAME(a_start_when_idle, start, !busy_reg)
    `RC4D_ASSERT_NEXT(a_last_step_ends, busy_reg && rom_cw.last && !stall, !busy_reg)
    `RC4D_ASSERT_NEXT(a_stall_holds_pc, stall, busy_reg && $stable(pc_reg))
    `RC4D_ASSERT_SAME(a_pc_in_program, busy_reg, pc_reg <= rc4d_pkg::S_LAST)

endmodule

// ===== hw/rtl/rc4d_dp.sv =====
`timescale 1ns / 1ps

module rc4d_dp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  rc4d_pkg::ctrl_t                        cw,
    input  logic                                   start,
    input  logic [7:0]                             cipher_byte,
    input  logic [rc4d_pkg::MAX_KEY_BYTES-1:0][7:0] key_bytes,
    input  logic [rc4d_pkg::KLEN_W-1:0]            key_len,
    output rc4d_pkg::stat_t                        stat,
    output logic [7:0]                             plain_byte
);

    logic [7:0] sbox_mem [rc4d_pkg::SBOX_DEPTH];
    logic [7:0] mem_q_reg;

    logic [7:0]                  n_reg, n_next;
    logic [7:0]                  i_reg, i_next;
    logic [7:0]                  j_reg, j_next;
    logic [rc4d_pkg::KIDX_W-1:0] kidx_reg, kidx_next;
    logic [rc4d_pkg::DROP_W-1:0] drop_reg, drop_next;
    logic                        keyed_reg;
    logic [7:0]                  a_reg, b_reg, cipher_reg;

    logic [7:0] key_byte;
    logic [7:0] sum_addr;
    logic [7:0] rd_addr, wr_addr, wr_data;
    logic [7:0] ks_byte;
    logic       k_last;

    assign key_byte = key_bytes[kidx_reg];
    assign sum_addr = a_reg + b_reg;
    assign k_last   = (rc4d_pkg::KLEN_W'(kidx_reg) == key_len - rc4d_pkg::KLEN_W'(1));

    always_comb begin
        case (cw.j_op)
            rc4d_pkg::J_HOLD: j_next = j_reg;
            rc4d_pkg::J_CLR:  j_next = 8'd0;
            rc4d_pkg::J_KSA:  j_next = j_reg + mem_q_reg + key_byte;
            rc4d_pkg::J_GEN:  j_next = j_reg + mem_q_reg;
            default:          j_next = j_reg;
        endcase
    end

    always_comb begin
        case (cw.i_op)
            rc4d_pkg::I_HOLD: i_next = i_reg;
            rc4d_pkg::I_CLR:  i_next = 8'd0;
            rc4d_pkg::I_INC:  i_next = i_reg + 8'd1;
            default:          i_next = i_reg;
        endcase
    end

    always_comb begin
        case (cw.k_op)
            rc4d_pkg::K_HOLD: kidx_next = kidx_reg;
            rc4d_pkg::K_CLR:  kidx_next = '0;
            rc4d_pkg::K_STEP: kidx_next = k_last ? '0 : kidx_reg + rc4d_pkg::KIDX_W'(1);
            default:          kidx_next = kidx_reg;
        endcase
    end

    always_comb begin
        case (cw.drop_op)
            rc4d_pkg::D_HOLD: drop_next = drop_reg;
            rc4d_pkg::D_LOAD: drop_next = rc4d_pkg::DROP_W'(rc4d_pkg::DROP_COUNT);
            rc4d_pkg::D_DEC:  drop_next = drop_reg - rc4d_pkg::DROP_W'(1);
            default:          drop_next = drop_reg;
        endcase
    end

    assign n_next = cw.n_inc ? n_reg + 8'd1 : n_reg;

    always_comb begin
        case (cw.rd_sel)
            rc4d_pkg::RD_N:      rd_addr = n_reg;
            rc4d_pkg::RD_J_NEXT: rd_addr = j_next;
            rc4d_pkg::RD_I_NEXT: rd_addr = i_next;
            rc4d_pkg::RD_SUM:    rd_addr = sum_addr;
            default:             rd_addr = n_reg;
        endcase
    end

    always_comb begin
        case (cw.wa_sel)
            rc4d_pkg::WA_N: wr_addr = n_reg;
            rc4d_pkg::WA_J: wr_addr = j_reg;
            rc4d_pkg::WA_I: wr_addr = i_reg;
            default:        wr_addr = n_reg;
        endcase
    end

    always_comb begin
        case (cw.wd_sel)
            rc4d_pkg::WD_N: wr_data = n_reg;
            rc4d_pkg::WD_A: wr_data = a_reg;
            rc4d_pkg::WD_B: wr_data = b_reg;
            default:        wr_data = n_reg;
        endcase
    end

    // The output read is issued in the same cycle as the write of sbox[i].
    // When it hits i, the read sees the old entry, so the swapped value is taken.
    assign ks_byte    = (sum_addr == i_reg) ? b_reg : mem_q_reg;
    assign plain_byte = cipher_reg ^ ks_byte;

    always_ff @(posedge aclk) begin
        if (cw.we) begin
            sbox_mem[wr_addr] <= wr_data;
        end
        if (cw.re) begin
            mem_q_reg <= sbox_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cw.a_ld) begin
            a_reg <= mem_q_reg;
        end
        if (cw.b_ld) begin
            b_reg <= mem_q_reg;
        end
        if (start) begin
            cipher_reg <= cipher_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg     <= 8'd0;
            i_reg     <= 8'd0;
            j_reg     <= 8'd0;
            kidx_reg  <= '0;
            drop_reg  <= '0;
            keyed_reg <= 1'b0;
        end else begin
            n_reg    <= n_next;
            i_reg    <= i_next;
            j_reg    <= j_next;
            kidx_reg <= kidx_next;
            drop_reg <= drop_next;
            if (cw.set_keyed) begin
                keyed_reg <= 1'b1;
            end
        end
    end

    assign stat.n_more    = (n_reg != 8'hFF);
    assign stat.drop_more = (drop_reg != rc4d_pkg::DROP_W'(1));
    assign stat.keyed     = keyed_reg;

endmodule

// ===== hw/rtl/rc4_drop_stream_decrypt.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Contents
// s_axis    in         tdata: cipher_byte[7:0]; tuser: func (0 rekey, 1 decrypt)
// m_axis    out        tdata: plain_byte[7:0]; tuser: not_keyed
// cfg       in         cfg_we, cfg_index (register 0..4), cfg_wdata[63:0]
//
// A microcoded sequencer drives one 256x8 state RAM with one read and one write port.
// A decrypt word runs 5 sequencer steps.
// A rekey word runs 16642 steps: 256 fill, 4 x 256 key schedule, 1 setup, 5 x 3072 drop, 1.
// A decrypt word before any rekey runs 1 step. A new word is taken once the sequencer is idle.
// Reset clears indices, key registers and the keyed flag; the RAM is written by the next rekey.
// A result step waits while the output register holds an untaken word.

module rc4_drop_stream_decrypt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] cipher_byte
    input  logic                          s_axis_tuser,  // [0] func
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,  // [7:0] plain_byte
    output logic                          m_axis_tuser,  // [0] not_keyed
    input  logic                          cfg_we,
    input  logic [rc4d_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [rc4d_pkg::CFG_W-1:0]    cfg_wdata
);

    logic [rc4d_pkg::KLEN_W-1:0] key_len_reg;
    logic [rc4d_pkg::KLEN_W-1:0] key_len_eff;
    logic [rc4d_pkg::CFG_W-1:0]  key_low_reg, key_second_reg, key_third_reg, key_high_reg;
    logic [rc4d_pkg::MAX_KEY_BYTES-1:0][7:0] key_bytes;

    logic             start;
    logic             busy;
    logic             out_full;
    rc4d_pkg::ctrl_t  cw;
    rc4d_pkg::stat_t  stat;
    logic [7:0]       plain_byte;

    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_data_reg;
    logic             m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_len_reg    <= rc4d_pkg::KLEN_W'(16);
            key_low_reg    <= '0;
            key_second_reg <= '0;
            key_third_reg  <= '0;
            key_high_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                rc4d_pkg::REG_KEY_LENGTH: key_len_reg    <= cfg_wdata[rc4d_pkg::KLEN_W-1:0];
                rc4d_pkg::REG_KEY_LOW:    key_low_reg    <= cfg_wdata;
                rc4d_pkg::REG_KEY_SECOND: key_second_reg <= cfg_wdata;
                rc4d_pkg::REG_KEY_THIRD:  key_third_reg  <= cfg_wdata;
                rc4d_pkg::REG_KEY_HIGH:   key_high_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A length of zero means one byte; lengths past the key store saturate.
    always_comb begin
        if (key_len_reg == '0) begin
            key_len_eff = rc4d_pkg::KLEN_W'(1);
        end else if (key_len_reg > rc4d_pkg::KLEN_W'(rc4d_pkg::MAX_KEY_BYTES)) begin
            key_len_eff = rc4d_pkg::KLEN_W'(rc4d_pkg::MAX_KEY_BYTES);
        end else begin
            key_len_eff = key_len_reg;
        end
    end

    assign key_bytes = {key_high_reg, key_third_reg, key_second_reg, key_low_reg};

    assign s_axis_tready = !busy;
    assign start         = s_axis_tvalid && !busy;
    assign out_full      = m_valid_reg && !m_axis_tready;

    rc4d_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .func     (s_axis_tuser),
        .stat     (stat),
        .out_full (out_full),
        .busy     (busy),
        .cw       (cw)
    );

    rc4d_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cw          (cw),
        .start       (start),
        .cipher_byte (s_axis_tdata),
        .key_bytes   (key_bytes),
        .key_len     (key_len_eff),
        .stat        (stat),
        .plain_byte  (plain_byte)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cw.emit != rc4d_pkg::E_NONE) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (cw.emit)
            rc4d_pkg::E_PLAIN: begin
                m_data_reg <= plain_byte;
                m_user_reg <= 1'b0;
            end
            rc4d_pkg::E_ERR: begin
                m_data_reg <= 8'd0;
                m_user_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule
